// ===== hdl/sdtg_pkg.sv =====
// Package for the sky dome texcoord generator: widths, codes, word types
// and small helpers shared by every stage. No dependencies.
package sdtg_pkg;

    localparam int COORD_W = 24;
    localparam int TIME_W  = 32;
    localparam int TEX_W   = 20;
    localparam int IDX_W   = 3;
    localparam int OFS_W   = 23;              // scroll offset, Q.16 modulo 128
    localparam int RADIUS  = 6 * 63;          // 378
    localparam int NUM_W   = 33;              // RADIUS * |d|
    localparam int RAD_W   = 62;              // sqrt radicand, even width
    localparam int ROOT_W  = RAD_W / 2;       // 31
    localparam int SQ_STEPS = ROOT_W;
    localparam int Q_W     = 25;              // quotient bits
    localparam int NP_W    = NUM_W + 21;      // numerator plus rounding bias
    localparam int TEX_MAX = 524287;
    localparam int TEX_MIN = -524288;

    localparam logic [IDX_W-1:0] CFG_EYE_X  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_EYE_Y  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_EYE_Z  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_TIME   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LAYER  = 3'd4;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [NUM_W-1:0]  n_x;
        logic [NUM_W-1:0]  n_y;
        logic              sign_x;
        logic              sign_y;
        logic              degen;
    } sq_word_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem_x;
        logic [ROOT_W-1:0] rem_y;
        logic [Q_W-1:0]    low_x;
        logic [Q_W-1:0]    low_y;
        logic [Q_W-1:0]    q_x;
        logic [Q_W-1:0]    q_y;
        logic [ROOT_W-1:0] len;
        logic              sign_x;
        logic              sign_y;
        logic              degen;
    } div_word_t;

    // Round (offset + part) / 128 half toward plus infinity, then clamp.
    function automatic logic [TEX_W-1:0] tex_finish(input logic [OFS_W-1:0] ofs,
                                                     input logic [Q_W-1:0] q,
                                                     input logic neg,
                                                     input logic zero);
        logic signed [Q_W+1:0] part;
        logic signed [Q_W+2:0] total;
        logic signed [Q_W+2:0] r;
        begin
            part  = zero ? '0 : (neg ? -$signed({2'b00, q}) : $signed({2'b00, q}));
            total = $signed({{(Q_W+3-OFS_W){1'b0}}, ofs}) + (Q_W+3)'(part) + (Q_W+3)'(64);
            r     = total >>> 7;
            if (r > (Q_W+3)'(TEX_MAX))
                tex_finish = TEX_W'(TEX_MAX);
            else if (r < (Q_W+3)'(TEX_MIN))
                tex_finish = TEX_W'(TEX_MIN);
            else
                tex_finish = r[TEX_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/sdtg_front.sv =====
// Front stages: direction from eye, magnitudes, squares and radicand.
// Depends on sdtg_pkg.
module sdtg_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sdtg_pkg::COORD_W-1:0]   vert_x,
    input  logic [sdtg_pkg::COORD_W-1:0]   vert_y,
    input  logic [sdtg_pkg::COORD_W-1:0]   vert_z,
    input  logic [sdtg_pkg::COORD_W-1:0]   eye_x,
    input  logic [sdtg_pkg::COORD_W-1:0]   eye_y,
    input  logic [sdtg_pkg::COORD_W-1:0]   eye_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sdtg_pkg::sq_word_t             out_word
);
    import sdtg_pkg::*;

    logic               va_reg, vb_reg, vc_reg;
    logic               rdy_a, rdy_b, rdy_c;
    logic signed [24:0] dx_reg, dy_reg;
    logic signed [26:0] dz_reg;
    logic signed [24:0] dz_raw;
    logic [24:0]        ax_next, ay_next;
    logic [25:0]        az_next;
    logic [48:0]        sx_reg, sy_reg;
    logic [51:0]        sz_reg;
    logic [NUM_W-1:0]   nx_reg, ny_reg;
    logic               sgx_b_reg, sgy_b_reg;
    logic [52:0]        sum;
    sq_word_t           word_reg;

    assign rdy_c    = !vc_reg || out_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    assign dz_raw  = $signed({vert_z[23], vert_z}) - $signed({eye_z[23], eye_z});
    assign ax_next = dx_reg[24] ? 25'(-dx_reg) : 25'(dx_reg);
    assign ay_next = dy_reg[24] ? 25'(-dy_reg) : 25'(dy_reg);
    assign az_next = dz_reg[26] ? 26'(-dz_reg) : 26'(dz_reg);
    assign sum     = 53'(sx_reg) + 53'(sy_reg) + 53'(sz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) va_reg <= in_valid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            dx_reg <= $signed({vert_x[23], vert_x}) - $signed({eye_x[23], eye_x});
            dy_reg <= $signed({vert_y[23], vert_y}) - $signed({eye_y[23], eye_y});
            dz_reg <= 27'(dz_raw) * 27'sd3;
        end
        if (rdy_b && va_reg)
        begin
            sx_reg    <= 49'(ax_next) * 49'(ax_next);
            sy_reg    <= 49'(ay_next) * 49'(ay_next);
            sz_reg    <= 52'(az_next) * 52'(az_next);
            nx_reg    <= NUM_W'(ax_next) * NUM_W'(RADIUS);
            ny_reg    <= NUM_W'(ay_next) * NUM_W'(RADIUS);
            sgx_b_reg <= dx_reg[24];
            sgy_b_reg <= dy_reg[24];
        end
        if (rdy_c && vb_reg)
        begin
            word_reg.rad    <= {1'b0, sum, 8'h00};
            word_reg.rem    <= '0;
            word_reg.root   <= '0;
            word_reg.n_x    <= nx_reg;
            word_reg.n_y    <= ny_reg;
            word_reg.sign_x <= sgx_b_reg;
            word_reg.sign_y <= sgy_b_reg;
            word_reg.degen  <= (sum == '0);
        end
    end

    assign out_valid = vc_reg;
    assign out_word  = word_reg;

endmodule

// ===== hdl/sdtg_sqrt_cell.sv =====
// One digit cell of the square root chain: takes two radicand bits, makes
// one root bit. Depends on sdtg_pkg.
module sdtg_sqrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdtg_pkg::sq_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output sdtg_pkg::sq_word_t  out_word
);
    import sdtg_pkg::*;

    logic              valid_reg;
    sq_word_t          word_reg;
    sq_word_t          word_next;
    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic              ge;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        rem_sh    = {in_word.rem, in_word.rad[RAD_W-1 -: 2]};
        trial     = {2'b00, in_word.root, 2'b01};
        ge        = rem_sh >= trial;
        word_next = in_word;
        word_next.rad  = {in_word.rad[RAD_W-3:0], 2'b00};
        word_next.rem  = ge ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
        word_next.root = {in_word.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hdl/sdtg_div_cell.sv =====
// One restoring division cell: one quotient bit for both s and t lanes.
// Depends on sdtg_pkg.
module sdtg_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sdtg_pkg::div_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sdtg_pkg::div_word_t  out_word
);
    import sdtg_pkg::*;

    logic            valid_reg;
    div_word_t       word_reg;
    div_word_t       word_next;
    logic [ROOT_W:0] tx, ty;
    logic            gx, gy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        tx = {in_word.rem_x, in_word.low_x[Q_W-1]};
        ty = {in_word.rem_y, in_word.low_y[Q_W-1]};
        gx = tx >= {1'b0, in_word.len};
        gy = ty >= {1'b0, in_word.len};
        word_next = in_word;
        word_next.rem_x = gx ? ROOT_W'(tx - {1'b0, in_word.len}) : ROOT_W'(tx);
        word_next.rem_y = gy ? ROOT_W'(ty - {1'b0, in_word.len}) : ROOT_W'(ty);
        word_next.low_x = {in_word.low_x[Q_W-2:0], 1'b0};
        word_next.low_y = {in_word.low_y[Q_W-2:0], 1'b0};
        word_next.q_x   = {in_word.q_x[Q_W-2:0], gx};
        word_next.q_y   = {in_word.q_y[Q_W-2:0], gy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hdl/sky_dome_texcoord_generator_top.sv =====
// Top level of the sky dome texcoord generator: config registers, stage chain
// and output register. Depends on sdtg_pkg, sdtg_front, sdtg_sqrt_cell, sdtg_div_cell.
//
// Usage:
//   Vertices enter on the s_* stream, one word per vertex. Each word gives
//   one result word on m_* carrying tex_s, tex_t and the degenerate flag.
//   The view origin, scene time and sky layer are written on the cfg_*
//   channel (index 0..4 as eye_x, eye_y, eye_z, scene_time, sky_layer;
//   other indexes are dropped). cfg_ready is always high. Write them only
//   while no vertex is in flight.
//   The chain is 3 front stages (difference, squares, sum), 31
//   square-root cells (one root bit each), one setup stage, 25 divider
//   cells (one quotient bit each for s and t) and the output register.
//   Throughput: one vertex per cycle while m_tready is high; each cell holds one word.
//   Each cell advances when it is empty or its neighbor downstream takes
//   its word, so a stalled receiver fills the chain one cell at a time and
//   s_tready drops only once every cell holds a word.
//   Reset clears all valid bits and all config registers to zero.
module sky_dome_texcoord_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // vert_x [23:0], vert_y [47:24], vert_z [71:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // tex_s [19:0], tex_t [39:20]
    output logic        m_tuser    // degenerate
);
    import sdtg_pkg::*;

    logic [COORD_W-1:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               layer_reg;
    logic [OFS_W-1:0]   offset;

    logic               fr_valid, fr_ready;
    sq_word_t           fr_word;

    logic      sq_valid [SQ_STEPS+1];
    logic      sq_ready [SQ_STEPS+1];
    sq_word_t  sq_word  [SQ_STEPS+1];

    logic      dv_valid [Q_W+1];
    logic      dv_ready [Q_W+1];
    div_word_t dv_word  [Q_W+1];

    logic               prep_valid_reg;
    div_word_t          prep_reg;
    logic [NP_W-1:0]    npx, npy;
    logic               out_valid_reg;
    logic [TEX_W-1:0]   s_reg, t_reg;
    logic               degen_reg;
    logic               out_ready_int;
    logic [16:0]        ofs_round;

    // Configuration: always ready, unknown indexes dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg <= '0;
            eye_y_reg <= '0;
            eye_z_reg <= '0;
            time_reg  <= '0;
            layer_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EYE_X: eye_x_reg <= cfg_data[COORD_W-1:0];
                CFG_EYE_Y: eye_y_reg <= cfg_data[COORD_W-1:0];
                CFG_EYE_Z: eye_z_reg <= cfg_data[COORD_W-1:0];
                CFG_TIME:  time_reg  <= cfg_data;
                CFG_LAYER: layer_reg <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // Scroll offset: time times 8 or 16, wrapped at 128 (Q.16).
    assign offset = layer_reg ? {time_reg[OFS_W-5:0], 4'h0} : {time_reg[OFS_W-4:0], 3'h0};

    sdtg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vert_x    (s_tdata[23:0]),
        .vert_y    (s_tdata[47:24]),
        .vert_z    (s_tdata[71:48]),
        .eye_x     (eye_x_reg),
        .eye_y     (eye_y_reg),
        .eye_z     (eye_z_reg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_word  (fr_word)
    );

    assign sq_valid[0] = fr_valid;
    assign sq_word[0]  = fr_word;
    assign fr_ready    = sq_ready[0];

    // Square root chain: one root bit per cell.
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        sdtg_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[i]),
            .in_ready  (sq_ready[i]),
            .in_word   (sq_word[i]),
            .out_valid (sq_valid[i+1]),
            .out_ready (sq_ready[i+1]),
            .out_word  (sq_word[i+1])
        );
    end

    // Setup: add half the length for rounding and split the numerator.
    assign sq_ready[SQ_STEPS] = !prep_valid_reg || dv_ready[0];
    assign npx = {sq_word[SQ_STEPS].n_x, 20'h00000} + NP_W'(sq_word[SQ_STEPS].root >> 1);
    assign npy = {sq_word[SQ_STEPS].n_y, 20'h00000} + NP_W'(sq_word[SQ_STEPS].root >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (sq_ready[SQ_STEPS])
            prep_valid_reg <= sq_valid[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready[SQ_STEPS] && sq_valid[SQ_STEPS])
        begin
            prep_reg.rem_x  <= ROOT_W'(npx[NP_W-1:Q_W]);
            prep_reg.rem_y  <= ROOT_W'(npy[NP_W-1:Q_W]);
            prep_reg.low_x  <= npx[Q_W-1:0];
            prep_reg.low_y  <= npy[Q_W-1:0];
            prep_reg.q_x    <= '0;
            prep_reg.q_y    <= '0;
            prep_reg.len    <= sq_word[SQ_STEPS].root;
            prep_reg.sign_x <= sq_word[SQ_STEPS].sign_x;
            prep_reg.sign_y <= sq_word[SQ_STEPS].sign_y;
            prep_reg.degen  <= sq_word[SQ_STEPS].degen;
        end
    end

    assign dv_valid[0] = prep_valid_reg;
    assign dv_word[0]  = prep_reg;

    // Divider chain: one quotient bit per cell for both lanes.
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        sdtg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .in_ready  (dv_ready[j]),
            .in_word   (dv_word[j]),
            .out_valid (dv_valid[j+1]),
            .out_ready (dv_ready[j+1]),
            .out_word  (dv_word[j+1])
        );
    end

    // Output register: apply sign, add offset, round and clamp.
    assign out_ready_int     = !out_valid_reg || m_tready;
    assign dv_ready[Q_W]     = out_ready_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready_int)
            out_valid_reg <= dv_valid[Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready_int && dv_valid[Q_W])
        begin
            s_reg     <= tex_finish(offset, dv_word[Q_W].q_x, dv_word[Q_W].sign_x,
                                    dv_word[Q_W].degen);
            t_reg     <= tex_finish(offset, dv_word[Q_W].q_y, dv_word[Q_W].sign_y,
                                    dv_word[Q_W].degen);
            degen_reg <= dv_word[Q_W].degen;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {t_reg, s_reg};
    assign m_tuser  = degen_reg;

    assign ofs_round = 17'(({1'b0, offset} + 24'd64) >> 7);

    // A degenerate vertex gets the bare scroll offset on both coordinates.
    a_degen_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[19:0] == m_tdata[39:20]))
        else $error("degenerate result with unequal s and t");

    a_degen_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[19:0] == {3'b000, ofs_round}))
        else $error("degenerate result differs from rounded offset");

    // An empty output register lets every cell advance.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

endmodule

// ===== tb/sky_dome_texcoord_generator_top_tb.sv =====
// Testbench for sky_dome_texcoord_generator_top: streams vertices through the
// block under several view/time/layer settings and checks every texcoord word
// against an in-bench predictor. Depends on sdtg_pkg and the RTL top level.
module sky_dome_texcoord_generator_top_tb;
    import sdtg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // idle cycles before giving up
    localparam int DRAIN_CYCLES   = 80;     // longer than the latency through the chain
    localparam int LONG_HOLD      = 400;    // receiver hold-off, well past chain depth

    typedef struct packed {
        logic [TEX_W-1:0] s;
        logic [TEX_W-1:0] t;
        logic             degen;
    } texcoord_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;

    // Shadow copy of the view registers, updated when each write is taken.
    logic signed [COORD_W-1:0] eye_x_q, eye_y_q, eye_z_q;
    logic [TIME_W-1:0]         time_q;
    logic                      layer_q;

    logic [71:0] vertex_q[$];       // vertices waiting to be offered
    texcoord_t   texcoord_exp_q[$]; // predicted texcoords, oldest first

    int  mismatches;
    int  failures;
    int  idle_cycles;
    bit  send_burst;     // while set, the sender offers back to back
    bit  recv_burst;     // while set, the receiver never stalls
    bit  long_hold_req;  // ask the receiver for one long hold-off
    int  send_gap;
    int  recv_gap;
    int  hold_cnt;

    sky_dome_texcoord_generator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // vert_x [23:0], vert_y [47:24], vert_z [71:48]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // tex_s [19:0], tex_t [39:20]
        .m_tuser   (m_tuser)    // degenerate
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Bitwise integer square root, floor.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    // RADIUS * d / len in Q.16 (len in Q.4), rounded half away from zero.
    function automatic longint scale_to_dome(input longint d, input longint unsigned len12);
        longint unsigned num;
        longint unsigned q;
        begin
            num = longint'(RADIUS) * ((d < 0) ? -d : d) * (64'd1 << 20);
            q   = (num + len12 / 2) / len12;
            return (d < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    // (offset + part) / 128, half toward plus infinity, then saturate.
    function automatic logic [TEX_W-1:0] scroll_and_clamp(input longint ofs, input longint part);
        longint r;
        begin
            r = (ofs + part + 64) >>> 7;
            if (r > TEX_MAX)
                r = TEX_MAX;
            if (r < TEX_MIN)
                r = TEX_MIN;
            return r[TEX_W-1:0];
        end
    endfunction

    function automatic texcoord_t predict_texcoord(input logic [71:0] v);
        longint          dx, dy, dz, ofs, ps, pt;
        longint unsigned len2, len12;
        texcoord_t       tc;
        begin
            dx   = longint'($signed(v[23:0]))  - longint'(eye_x_q);
            dy   = longint'($signed(v[47:24])) - longint'(eye_y_q);
            dz   = 3 * (longint'($signed(v[71:48])) - longint'(eye_z_q));
            len2 = dx * dx + dy * dy + dz * dz;
            ofs  = longint'((64'(time_q) << (layer_q ? 4 : 3)) & ((64'd1 << OFS_W) - 1));
            ps   = 0;
            pt   = 0;
            if (len2 != 0)
            begin
                len12 = int_sqrt(len2 << 8);
                ps    = scale_to_dome(dx, len12);
                pt    = scale_to_dome(dy, len12);
            end
            tc.s     = scroll_and_clamp(ofs, ps);
            tc.t     = scroll_and_clamp(ofs, pt);
            tc.degen = (len2 == 0);
            return tc;
        end
    endfunction

    // Driver: offer queued vertices with random gaps, predict on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                texcoord_exp_q.push_back(predict_texcoord(s_tdata));
            if (s_tvalid && !s_tready)
                ;   // hold the word until it is taken
            else if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (vertex_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= vertex_q.pop_front();
                send_gap <= send_burst ? 0 : $urandom_range(0, 17);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: random stalls, one long hold-off on request, compare each word.
    always @(posedge clk or negedge rst_n)
    begin
        texcoord_t want;
        texcoord_t got;
        int        gap;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
            hold_cnt <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[19:0], m_tdata[39:20], m_tuser};
                if (texcoord_exp_q.size() == 0)
                begin
                    failures <= failures + 1;
                    if (mismatches < 10)
                        $display("unexpected texcoord word s=%h t=%h degen=%b",
                                 got.s, got.t, got.degen);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = texcoord_exp_q.pop_front();
                    if (got !== want)
                    begin
                        failures <= failures + 1;
                        if (mismatches < 10)
                            $display("texcoord mismatch: exp s=%h t=%h degen=%b, got s=%h t=%h degen=%b",
                                     want.s, want.t, want.degen, got.s, got.t, got.degen);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (long_hold_req && hold_cnt == 0)
            begin
                long_hold_req = 1'b0;
                hold_cnt <= LONG_HOLD;
                m_tready <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= (hold_cnt == 1);
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= (recv_gap == 1);
            end
            else if (m_tvalid && m_tready)
            begin
                // draw a new wait for the next word
                if (recv_burst)
                    m_tready <= 1'b1;
                else
                begin
                    gap = $urandom_range(0, 17);
                    recv_gap <= gap;
                    m_tready <= (gap == 0);
                end
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Write one register and mirror it in the shadow copy.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        begin
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            case (idx)
                CFG_EYE_X: eye_x_q = data[COORD_W-1:0];
                CFG_EYE_Y: eye_y_q = data[COORD_W-1:0];
                CFG_EYE_Z: eye_z_q = data[COORD_W-1:0];
                CFG_TIME:  time_q  = data;
                CFG_LAYER: layer_q = data[0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    endtask

    // Wait until the chain is empty, then give it time to settle.
    task automatic wait_drained();
        begin
            while (vertex_q.size() > 0 || s_tvalid || texcoord_exp_q.size() > 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    function automatic logic [23:0] pick_coord(input int mode, input logic [23:0] eye);
        begin
            case (mode)
                0: return 24'h800000;
                1: return 24'h7FFFFF;
                2: return eye + 24'($signed($urandom_range(0, 16)) - 8);
                default: return 24'($urandom());
            endcase
        end
    endfunction

    function automatic logic [71:0] random_vertex();
        int mode;
        begin
            mode = $urandom_range(0, 19);
            if (mode == 0)
                return {eye_z_q, eye_y_q, eye_x_q};   // vertex on the eye: zero length
            if (mode < 5)
                return {pick_coord(2, eye_z_q), pick_coord(2, eye_y_q), pick_coord(2, eye_x_q)};
            if (mode < 7)
                return {pick_coord($urandom_range(0, 3), eye_z_q),
                        pick_coord($urandom_range(0, 3), eye_y_q),
                        pick_coord($urandom_range(0, 3), eye_x_q)};
            return 72'({$urandom(), $urandom(), $urandom()});
        end
    endfunction

    initial
    begin
        logic [31:0] cfg_word;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        eye_x_q       = '0;
        eye_y_q       = '0;
        eye_z_q       = '0;
        time_q        = '0;
        layer_q       = 1'b0;
        mismatches    = 0;
        failures      = 0;
        idle_cycles   = 0;
        send_burst    = 1'b0;
        recv_burst    = 1'b0;
        long_hold_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed vertices at reset settings: eye at origin, no scroll.
        vertex_q.push_back(72'h0);                                  // zero length
        vertex_q.push_back({24'h0, 24'h0, 24'h7FFFFF});
        vertex_q.push_back({24'h0, 24'h0, 24'h800000});
        vertex_q.push_back({24'h0, 24'h7FFFFF, 24'h0});
        vertex_q.push_back({24'h0, 24'h800000, 24'h0});
        vertex_q.push_back({24'h7FFFFF, 24'h0, 24'h0});             // straight up
        vertex_q.push_back({24'h800000, 24'h0, 24'h0});
        vertex_q.push_back({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
        vertex_q.push_back({24'h800000, 24'h800000, 24'h800000});
        vertex_q.push_back({24'h000000, 24'h000001, 24'h000001});   // tiny length
        vertex_q.push_back({24'h000000, 24'hFFFFFF, 24'hFFFFFF});
        vertex_q.push_back({24'hFFFFFF, 24'h000000, 24'h000001});
        vertex_q.push_back({24'h000000, 24'h7FFFFF, 24'h800000});
        wait_drained();

        // Eye at extremes, full scroll, slow then fast layer; vertices on the eye and at the corners.
        write_reg(CFG_EYE_X, 32'hFF800000);   // upper bits must be dropped
        write_reg(CFG_EYE_Y, 32'h007FFFFF);
        write_reg(CFG_EYE_Z, 32'h00800000);
        write_reg(CFG_TIME, 32'hFFFFFFFF);
        write_reg(CFG_LAYER, 32'hFFFFFFFE);   // bit 0 clear: solid layer
        for (int i = CFG_LAYER + 1; i < 8; i++)
            write_reg(i[2:0], $urandom());    // unused indexes are ignored
        vertex_q.push_back({24'h800000, 24'h7FFFFF, 24'h800000});   // on the eye
        vertex_q.push_back({24'h7FFFFF, 24'h800000, 24'h7FFFFF});
        vertex_q.push_back({24'h800000, 24'h800000, 24'h7FFFFF});
        vertex_q.push_back({24'h7FFFFF, 24'h7FFFFF, 24'h800000});
        wait_drained();
        write_reg(CFG_LAYER, 32'h1);
        vertex_q.push_back({24'h800000, 24'h7FFFFF, 24'h800000});
        vertex_q.push_back({24'h7FFFFF, 24'h800000, 24'h7FFFFF});
        vertex_q.push_back({24'h000000, 24'h000000, 24'h000000});
        wait_drained();

        // Random phases, each under a fresh setting.
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int r = 0; r < 5; r++)
            begin
                case ($urandom_range(0, 3))
                    0: cfg_word = 32'h00800000;
                    1: cfg_word = 32'h007FFFFF;
                    2: cfg_word = 32'h0;
                    default: cfg_word = $urandom();
                endcase
                if (r == CFG_TIME && $urandom_range(0, 2) == 0)
                    cfg_word = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
                write_reg(r[2:0], cfg_word);
            end
            send_burst = (ph % 3 == 1);
            recv_burst = (ph % 3 == 2);
            for (int n = 0; n < 200; n++)
                vertex_q.push_back(random_vertex());
            if (ph == 3)
            begin
                // fill the chain against a stopped receiver
                send_burst    = 1'b1;
                long_hold_req = 1'b1;
            end
            wait_drained();
        end

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sdtg_pkg.sv
hdl/sdtg_front.sv
hdl/sdtg_sqrt_cell.sv
hdl/sdtg_div_cell.sv
hdl/sky_dome_texcoord_generator_top.sv
tb/sky_dome_texcoord_generator_top_tb.sv
